// File: hdl/mtkc_pkg.sv
// shared constants and types for the mersenne twister keystream byte cipher
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mtkc_pkg;

  localparam int STATE_WORDS = 624;
  localparam int SHIFT_WORDS = 397;
  localparam int IDX_W       = $clog2(STATE_WORDS);

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(STATE_WORDS - 1);
  localparam logic [IDX_W-1:0] SHIFT_IDX = IDX_W'(SHIFT_WORDS);
  localparam logic [IDX_W-1:0] WRAP_IDX  = IDX_W'(STATE_WORDS - SHIFT_WORDS);

  localparam logic [31:0] INIT_MULT  = 32'h6c07_8965;
  localparam logic [31:0] TWIST_MAT  = 32'h9908_b0df;
  localparam logic [31:0] UPPER_BIT  = 32'h8000_0000;
  localparam logic [31:0] LOWER_BITS = 32'h7fff_ffff;
  localparam logic [31:0] TEMPER_B   = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C   = 32'hefc6_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_WR,
    ST_READ,
    ST_TWIST,
    ST_DONE
  } state_t;

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] r;
    r = w ^ (w >> 11);
    r = r ^ ((r << 7) & TEMPER_B);
    r = r ^ ((r << 15) & TEMPER_C);
    r = r ^ (r >> 18);
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/mt19937_keystream_byte_cipher_core.sv
// top level of the mersenne twister keystream byte cipher
// depends on mtkc_pkg
`timescale 1ns / 1ps
`default_nettype none

// Byte stream cipher: each byte is XORed with bits 8..1 of the next tempered
// MT19937 word, so the same core both encrypts and decrypts. The 624-word
// generator state lives in one memory with two registered read ports and one
// write port. The twist is done in place, one word per draw: a draw reads
// words i+1 and i+397, keeps word i from the previous draw, and writes the
// new word i back. A data byte passes through the memory read, the twist
// and temper step and the output register, and the next byte is accepted
// only once its result is loaded into the output register. A beat with
// start_of_message set first reseeds the memory, one word at a time, since
// each word needs the registered multiply of the one before it. Until the
// first seed, bytes pass through unchanged with not_seeded high. A result
// waits in the output register while the next beat is taken.
module mt19937_keystream_byte_cipher_core
  import mtkc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        start_of_message,
  input  wire logic [31:0] seed,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       result_byte,
  output logic             not_seeded
);

  state_t state, state_next;

  logic [31:0] mem [STATE_WORDS];
  logic [31:0] rd_a, rd_b;
  logic [IDX_W-1:0] addr_a, addr_b;

  logic [IDX_W-1:0] idx;
  logic             seeded;
  logic [31:0]      prev_word;
  logic [31:0]      prod;
  logic [31:0]      cur_word;
  logic [7:0]       data_r;
  logic [7:0]       res_byte;
  logic             res_ns;

  logic             accept;
  logic             out_load;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [31:0]      mem_wdata;

  logic [31:0] seed_word;
  logic [31:0] twist_y;
  logic [31:0] twist_word;
  logic [31:0] tempered;
  logic [IDX_W-1:0] idx_inc;

  assign accept   = in_valid && in_ready;
  assign idx_inc  = (idx == LAST_IDX) ? '0 : idx + 1'b1;

  // read addresses always follow the draw index
  assign addr_a = idx_inc;
  assign addr_b = (idx >= WRAP_IDX) ? idx - WRAP_IDX : idx + SHIFT_IDX;

  assign seed_word  = {{(32-IDX_W){1'b0}}, idx} + prod;
  assign twist_y    = (cur_word & UPPER_BIT) | (rd_a & LOWER_BITS);
  assign twist_word = rd_b ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_MAT : 32'h0);
  assign tempered   = temper(twist_word);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (start_of_message) state_next = ST_SEED_MUL;
          else if (seeded) state_next = ST_TWIST;
          else state_next = ST_DONE;
        end
      end
      ST_SEED_MUL: state_next = ST_SEED_WR;
      ST_SEED_WR: begin
        if (idx == LAST_IDX) state_next = ST_READ;
        else state_next = ST_SEED_MUL;
      end
      ST_READ:  state_next = ST_TWIST;
      ST_TWIST: state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready  = 1'b0;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = twist_word;
    unique case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        mem_we    = in_valid && start_of_message;
        mem_waddr = '0;
        mem_wdata = seed;
      end
      ST_SEED_MUL: ;
      ST_SEED_WR: begin
        mem_we    = 1'b1;
        mem_wdata = seed_word;
      end
      ST_READ: ;
      ST_TWIST: mem_we = 1'b1;
      ST_DONE:  out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      seeded    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept && start_of_message) begin
            idx    <= IDX_W'(1);
            seeded <= 1'b1;
          end
        end
        ST_SEED_WR: idx <= idx_inc;
        ST_TWIST:   idx <= idx_inc;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          data_r   <= data_byte;
          res_byte <= data_byte;
          res_ns   <= 1'b1;
          if (start_of_message) begin
            prev_word <= seed;
            cur_word  <= seed;
          end
        end
      end
      ST_SEED_MUL: prod <= INIT_MULT * (prev_word ^ (prev_word >> 30));
      ST_SEED_WR:  prev_word <= seed_word;
      ST_TWIST: begin
        // word i+1 read now is word i of the next draw
        cur_word <= rd_a;
        res_byte <= data_r ^ tempered[8:1];
        res_ns   <= 1'b0;
      end
      default: ;
    endcase
    if (out_load) begin
      result_byte <= res_byte;
      not_seeded  <= res_ns;
    end
  end

endmodule

`default_nettype wire
